// ===== src/decal_pkg.sv =====
package decal_pkg;

  localparam int RISE_BINS       = 256;
  localparam int HEIGHT_BINS     = 2048;
  localparam int PIXELS_PER_SIDE = 128;

  localparam int PIX_COUNT = PIXELS_PER_SIDE * PIXELS_PER_SIDE;
  localparam int PAW       = $clog2(PIX_COUNT);

  // The energy table is split into even and odd height banks.
  localparam int HALF_H     = (HEIGHT_BINS + 1) / 2;
  localparam int BANK_DEPTH = RISE_BINS * HALF_H;
  localparam int TAW        = $clog2(BANK_DEPTH);
  localparam int HBW        = $clog2(HEIGHT_BINS);
  localparam int RBW        = (RISE_BINS > 2) ? $clog2(RISE_BINS) : 1;

  // Rounding division of the corrected rise by 98304 = 3 * 2^15.
  localparam int RISE_HALF = 49152;
  localparam int RECIP3    = 43691;

  typedef enum logic [1:0] {
    CMD_CALIB = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_TABLE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic low;
    logic high;
    logic hhigh;
  } flags_t;

endpackage

// ===== src/decal_ram.sv =====
module decal_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port that holds while stalled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/decal_rise.sv =====
module decal_rise
  import decal_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [7:0]         rise_code,
  input  logic [15:0]        gain,
  input  logic signed [15:0] offset,
  output logic [12:0]        k,
  output logic               neg
);

  logic signed [27:0] num;
  logic [10:0]        scale;
  logic [27:0]        mag;

  // Corrected rise numerator over a fixed denominator.
  assign scale = 11'(5 * rise_code + 30);

  always_ff @(posedge clk) begin
    if (en) begin
      num <= 28'($signed({1'b0, scale}) * $signed({1'b0, gain}))
             + 28'(offset * 28'sd384);
    end
  end

  // Magnitude plus half the denominator, then divide by 2^15.
  assign mag = 28'((num < 0) ? -num : num) + 28'(RISE_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      k   <= mag[27:15];
      neg <= num < 0;
    end
  end

endmodule

// ===== src/decal_interp.sv =====
module decal_interp
  import decal_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] t_even,
  input  logic signed [15:0] t_odd,
  input  logic               hb_odd,
  input  logic [15:0]        frac,
  output logic [15:0]        energy,
  output logic               clamped
);

  logic signed [15:0] t0;
  logic signed [15:0] t1;
  logic signed [16:0] diff;
  logic signed [15:0] t0_r;
  logic signed [33:0] prod;
  logic signed [34:0] e;

  // Pick the two neighbor words by parity of the height bin.
  assign t0   = hb_odd ? t_odd : t_even;
  assign t1   = hb_odd ? t_even : t_odd;
  assign diff = 17'(t1) - 17'(t0);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= diff * $signed({1'b0, frac});
      t0_r <= t0;
    end
  end

  // Sum, then clamp at zero and saturate at the top.
  assign e       = 35'(prod) + (35'(t0_r) <<< 1);
  assign clamped = e <= 0;

  always_comb begin
    if (e <= 0) begin
      energy = 16'd0;
    end else if (e > 35'sd65535) begin
      energy = 16'hFFFF;
    end else begin
      energy = e[15:0];
    end
  end

endmodule

// ===== src/detector_event_energy_calibration.sv =====
// Detector event energy calibration.
// Input channel: in_valid / in_stall with one port per field. The command
// field selects an event calibration, a pixel rise correction write or an
// energy table word write. Output channel: out_valid / out_stall, one beat
// per calibrated event and none for write or unknown commands.
// The pipeline takes one beat per cycle unless out_stall holds a waiting
// result. An accepted beat passes the pixel store read, the rise multiply,
// the divide by the rise denominator, the registered table read, the
// interpolation multiply and the output register.
// Writes to the table land in the same stage as table reads, so each event
// sees exactly the writes accepted before it.
// Reset clears all valid bits; stores are not cleared and must be written
// before use. When out_stall holds a waiting result, the whole pipeline
// freezes and in_stall rises; nothing is lost or repeated.
module detector_event_energy_calibration
  import decal_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [15:0]        pulse_height,
  input  logic [7:0]         rise_code,
  input  logic [7:0]         pixel_y,
  input  logic [7:0]         pixel_z,
  input  logic [7:0]         table_rise_bin,
  input  logic [10:0]        table_height_bin,
  input  logic [15:0]        new_rise_gain,
  input  logic signed [15:0] new_rise_offset,
  input  logic signed [15:0] new_table_energy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        energy,
  output logic [7:0]         rise_bin_out,
  output logic               bad_pixel,
  output logic               rise_low,
  output logic               rise_high,
  output logic               height_high,
  output logic               energy_clamped
);

  logic en;
  logic accept;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  cmd_t s1_cmd, s2_cmd, s3_cmd, s4_cmd, s5_cmd;
  logic [15:0] s1_pha, s2_pha, s3_pha;
  logic [7:0]  s1_rise;
  logic s1_bad, s2_bad, s3_bad;
  logic s1_tw, s2_tw, s3_tw;
  logic s1_todd, s2_todd, s3_todd;
  logic [TAW-1:0] s1_taddr, s2_taddr, s3_taddr;
  logic [15:0] s1_tdata, s2_tdata, s3_tdata;
  flags_t s4_flags, s5_flags;
  logic [RBW-1:0] s4_rb, s5_rb;
  logic s4_hodd;
  logic [15:0] s4_frac;

  logic [31:0] pix_rdata;
  logic pix_we;
  logic [PAW-1:0] pix_addr;
  logic in_range;

  logic [12:0] s3_k;
  logic s3_neg;
  logic [11:0] q;
  logic [RBW-1:0] rb;
  logic rlow, rhigh, hhigh;
  logic [HBW-1:0] hb;
  logic [TAW-1:0] ev_addr, od_addr;
  logic [15:0] t_even, t_odd;
  logic [15:0] ip_energy;
  logic ip_clamped;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // Pixel store, read and written at acceptance.
  assign in_range = (pixel_y < PIXELS_PER_SIDE) && (pixel_z < PIXELS_PER_SIDE);
  assign pix_addr = PAW'(pixel_y * PIXELS_PER_SIDE + pixel_z);
  assign pix_we   = accept && (cmd_t'(command) == CMD_PIXEL) && in_range;

  decal_ram #(.DEPTH(PIX_COUNT), .WIDTH(32), .AW(PAW)) u_pix (
    .clk(clk), .en(en), .we(pix_we), .waddr(pix_addr),
    .wdata({new_rise_gain, new_rise_offset}), .raddr(pix_addr), .rdata(pix_rdata)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid && (s5_cmd == CMD_CALIB);
    end
  end

  // Payload through the early stages, with the pending table write.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd   <= cmd_t'(command);
      s1_pha   <= pulse_height;
      s1_rise  <= rise_code;
      s1_bad   <= !in_range;
      s1_tw    <= (cmd_t'(command) == CMD_TABLE) && (table_rise_bin < RISE_BINS)
                  && (table_height_bin < HEIGHT_BINS);
      s1_todd  <= table_height_bin[0];
      s1_taddr <= TAW'(table_rise_bin * HALF_H + (table_height_bin >> 1));
      s1_tdata <= new_table_energy;
      s2_cmd   <= s1_cmd;
      s2_pha   <= s1_pha;
      s2_bad   <= s1_bad;
      s2_tw    <= s1_tw;
      s2_todd  <= s1_todd;
      s2_taddr <= s1_taddr;
      s2_tdata <= s1_tdata;
      s3_cmd   <= s2_cmd;
      s3_pha   <= s2_pha;
      s3_bad   <= s2_bad;
      s3_tw    <= s2_tw;
      s3_todd  <= s2_todd;
      s3_taddr <= s2_taddr;
      s3_tdata <= s2_tdata;
    end
  end

  decal_rise u_rise (
    .clk(clk), .en(en), .rise_code(s1_rise), .gain(pix_rdata[31:16]),
    .offset(pix_rdata[15:0]), .k(s3_k), .neg(s3_neg)
  );

  // Finish the divide by three, clamp rise and height bins.
  assign q = 12'((29'(s3_k) * 29'(RECIP3)) >> 17);

  always_comb begin
    rlow  = 1'b0;
    rhigh = 1'b0;
    rb    = RBW'(q);
    if (s3_neg && q != 12'd0) begin
      rlow = 1'b1;
      rb   = '0;
    end else if (s3_neg) begin
      rb = '0;
    end else if (q >= RISE_BINS) begin
      rhigh = 1'b1;
      rb    = RBW'(RISE_BINS - 1);
    end
  end

  always_comb begin
    hhigh = 1'b0;
    hb    = HBW'(s3_pha >> 1);
    if ((s3_pha >> 1) >= HEIGHT_BINS - 1) begin
      hhigh = 1'b1;
      hb    = HBW'(HEIGHT_BINS - 2);
    end
  end

  assign od_addr = TAW'(rb * HALF_H + (hb >> 1));
  assign ev_addr = TAW'(rb * HALF_H + (hb >> 1) + hb[0]);

  // Energy table banks.
  decal_ram #(.DEPTH(BANK_DEPTH), .WIDTH(16), .AW(TAW)) u_even (
    .clk(clk), .en(en), .we(en && s3_valid && s3_tw && !s3_todd),
    .waddr(s3_taddr), .wdata(s3_tdata), .raddr(ev_addr), .rdata(t_even)
  );

  decal_ram #(.DEPTH(BANK_DEPTH), .WIDTH(16), .AW(TAW)) u_odd (
    .clk(clk), .en(en), .we(en && s3_valid && s3_tw && s3_todd),
    .waddr(s3_taddr), .wdata(s3_tdata), .raddr(od_addr), .rdata(t_odd)
  );

  // Event side data around the table read and interpolation.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_cmd   <= s3_cmd;
      s4_flags <= '{bad: s3_bad, low: rlow, high: rhigh, hhigh: hhigh};
      s4_rb    <= rb;
      s4_hodd  <= hb[0];
      s4_frac  <= 16'(s3_pha - 16'({hb, 1'b0}));
      s5_cmd   <= s4_cmd;
      s5_flags <= s4_flags;
      s5_rb    <= s4_rb;
    end
  end

  decal_interp u_interp (
    .clk(clk), .en(en), .t_even(t_even), .t_odd(t_odd), .hb_odd(s4_hodd),
    .frac(s4_frac), .energy(ip_energy), .clamped(ip_clamped)
  );

  // Output register; a bad pixel zeroes everything but its flag.
  always_ff @(posedge clk) begin
    if (en) begin
      bad_pixel      <= s5_flags.bad;
      energy         <= s5_flags.bad ? 16'd0 : ip_energy;
      rise_bin_out   <= s5_flags.bad ? 8'd0 : 8'(s5_rb);
      rise_low       <= !s5_flags.bad && s5_flags.low;
      rise_high      <= !s5_flags.bad && s5_flags.high;
      height_high    <= !s5_flags.bad && s5_flags.hhigh;
      energy_clamped <= !s5_flags.bad && ip_clamped;
    end
  end

endmodule
